/* hw/rtl/stuffed_frame_receiver_macros.svh */
// assertion macros for the frame receiver
`ifndef STUFFED_FRAME_RECEIVER_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sfr_pkg.sv */
// shared types and codes for the stuffed frame receiver
`timescale 1ns / 1ps

package sfr_pkg;

  // result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // frame end status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_LONG = 3'd1;
  localparam logic [2:0] ST_BAD_CSUM = 3'd2;
  localparam logic [2:0] ST_NO_END   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  localparam logic [7:0] ESC_FLIP = 8'h20;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [7:0]  escape_marker;
    logic [15:0] max_payload;
    logic [23:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
    logic [2:0]  status;
  } res_t;

endpackage

/* hw/rtl/stuffed_frame_receiver.sv */
// top level of the byte-stuffed frame receiver
//
//  port group  direction  handshake               payload
//  in          sink       in_valid_i/in_ready_o   opcode_i, rx_byte_i
//  out         source     out_valid_o/out_ready_i kind_o .. status_o
//  apb         sink       psel/penable/pready     paddr, pwdata, prdata
//
// one beat per cycle sustained while results are taken; a beat passes the
// input register, then the result register, before its result is on the
// outputs
// reset returns the receiver to hunting and the registers to their defaults
// in_ready_o drops only while the input register is full and the result
// register holds a result that is not taken
`timescale 1ns / 1ps
`include "stuffed_frame_receiver_macros.svh"

module stuffed_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  frame_type_o,
  output logic [15:0] frame_length_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfr_pkg::*;

  cfg_t       cfg;
  res_t       res;
  logic       s1_valid_q;
  logic       s1_op_q;
  logic [7:0] s1_byte_q;
  logic       slot_free;
  logic       advance;
  res_t       out_q;

  sfr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign slot_free  = !out_q.valid || out_ready_i;
  assign advance    = s1_valid_q && slot_free;
  assign in_ready_o = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q   <= opcode_i;
      s1_byte_q <= rx_byte_i;
    end
  end

  sfr_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .opcode_i  (s1_op_q),
    .rx_byte_i (s1_byte_q),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (slot_free) begin
      if (advance && res.valid) begin
        out_q <= res;
      end else begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_q.valid;
  assign kind_o         = out_q.kind;
  assign frame_type_o   = out_q.frame_type;
  assign frame_length_o = out_q.frame_length;
  assign data_byte_o    = out_q.data_byte;
  assign status_o       = out_q.status;

  `SFR_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q, "input beat lost")
  `SFR_ASSERT_NOW(a_ready_when_empty, !out_q.valid, in_ready_o, "stall with empty output")
  `SFR_ASSERT_NOW(a_st_end, out_valid_o && kind_o != KIND_END, status_o == ST_OK, "bad status")

endmodule

/* hw/rtl/sfr_cfg_regs.sv */
// apb configuration registers for the frame receiver
`timescale 1ns / 1ps

module sfr_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output sfr_pkg::cfg_t cfg_o
);
  import sfr_pkg::*;

  localparam logic [2:0] REG_START   = 3'd0;
  localparam logic [2:0] REG_END     = 3'd1;
  localparam logic [2:0] REG_ESCAPE  = 3'd2;
  localparam logic [2:0] REG_MAX_LEN = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker  <= 8'd126;
      cfg_q.end_marker    <= 8'd127;
      cfg_q.escape_marker <= 8'd125;
      cfg_q.max_payload   <= 16'd1024;
      cfg_q.timeout_ticks <= 24'd1000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_START:   cfg_q.start_marker  <= pwdata[7:0];
        REG_END:     cfg_q.end_marker    <= pwdata[7:0];
        REG_ESCAPE:  cfg_q.escape_marker <= pwdata[7:0];
        REG_MAX_LEN: cfg_q.max_payload   <= pwdata[15:0];
        REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START:   prdata = {24'd0, cfg_q.start_marker};
      REG_END:     prdata = {24'd0, cfg_q.end_marker};
      REG_ESCAPE:  prdata = {24'd0, cfg_q.escape_marker};
      REG_MAX_LEN: prdata = {16'd0, cfg_q.max_payload};
      REG_TIMEOUT: prdata = {8'd0, cfg_q.timeout_ticks};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/sfr_deframer.sv */
// frame state and per-beat decode logic
`timescale 1ns / 1ps

module sfr_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfr_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic          opcode_i,
  input  logic [7:0]    rx_byte_i,
  output sfr_pkg::res_t res_o
);
  import sfr_pkg::*;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_TYPE   = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_CSUM   = 3'd5;
  localparam logic [2:0] PH_END    = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [7:0]  csum_q, csum_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic [23:0] idle_q, idle_d;

  logic        take;
  logic [7:0]  dec_b;
  logic [15:0] full_len;
  logic [15:0] left_dec;
  logic        emit;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic [2:0]  status;
  logic        fin;

  assign full_len = {len_q[15:8], dec_b};
  assign left_dec = left_q - 16'd1;

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    csum_d  = csum_q;
    type_d  = type_q;
    len_d   = len_q;
    left_d  = left_q;
    idle_d  = idle_q;
    take    = 1'b0;
    dec_b   = rx_byte_i;
    emit    = 1'b0;
    fin     = 1'b0;
    kind    = KIND_HDR;
    data    = 8'd0;
    status  = ST_OK;

    if (phase_q == PH_HUNT || phase_q > PH_END) begin
      phase_d = PH_HUNT;
      if (!opcode_i && rx_byte_i == cfg_i.start_marker) begin
        phase_d = PH_TYPE;
        esc_d   = 1'b0;
        csum_d  = 8'd0;
        type_d  = 8'd0;
        len_d   = 16'd0;
        left_d  = 16'd0;
        idle_d  = 24'd0;
      end
    end else if (opcode_i) begin
      idle_d = idle_q + 24'd1;
      if (idle_d >= cfg_i.timeout_ticks) begin
        fin    = 1'b1;
        status = ST_TIMEOUT;
      end
    end else begin
      idle_d = 24'd0;
      if (phase_q == PH_END) begin
        fin    = 1'b1;
        status = (rx_byte_i == cfg_i.end_marker) ? ST_OK : ST_NO_END;
      end else if (esc_q) begin
        esc_d = 1'b0;
        take  = 1'b1;
        dec_b = rx_byte_i ^ ESC_FLIP;
      end else if (rx_byte_i == cfg_i.escape_marker) begin
        esc_d = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    // un-escaped byte: header fields, payload or checksum
    if (take) begin
      csum_d = csum_q ^ dec_b;
      case (phase_q)
        PH_TYPE: begin
          type_d  = dec_b;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = {dec_b, 8'd0};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d = full_len;
          if (full_len > cfg_i.max_payload) begin
            fin    = 1'b1;
            status = ST_TOO_LONG;
          end else begin
            left_d  = full_len;
            phase_d = (full_len == 16'd0) ? PH_CSUM : PH_DATA;
            emit    = 1'b1;
            kind    = KIND_HDR;
          end
        end
        PH_DATA: begin
          left_d = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PH_CSUM;
          end
          emit = 1'b1;
          kind = KIND_DATA;
          data = dec_b;
        end
        PH_CSUM: begin
          if (csum_d != 8'd0) begin
            fin    = 1'b1;
            status = ST_BAD_CSUM;
          end else begin
            phase_d = PH_END;
          end
        end
        default: ;
      endcase
    end

    if (fin) begin
      phase_d = PH_HUNT;
      esc_d   = 1'b0;
      emit    = 1'b1;
      kind    = KIND_END;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      esc_q   <= 1'b0;
      csum_q  <= 8'd0;
      type_q  <= 8'd0;
      len_q   <= 16'd0;
      left_q  <= 16'd0;
      idle_q  <= 24'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      csum_q  <= csum_d;
      type_q  <= type_d;
      len_q   <= len_d;
      left_q  <= left_d;
      idle_q  <= idle_d;
    end
  end

  assign res_o.valid        = emit;
  assign res_o.kind         = kind;
  assign res_o.frame_type   = type_d;
  assign res_o.frame_length = len_d;
  assign res_o.data_byte    = data;
  assign res_o.status       = status;

endmodule
